// ===== sv/assert_macros.svh =====
// Assertion macros for the RTL files that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge, masked while reset is asserted.
`define CHK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check on every clock edge, reset cycles included.
`define CHK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/tlpq_pkg.sv =====
// Types and constants for the three-level priority queue.
`default_nettype none

package tlpq_pkg;

  localparam int CAPACITY = 16;
  localparam int ID_W     = 16;
  localparam int LVL_W    = 2;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = $clog2(CAPACITY);

  localparam logic [LVL_W-1:0] LVL_TOP = 2'd2;

  typedef enum logic [1:0] {
    CMD_ENQ  = 2'd0,
    CMD_DEQ  = 2'd1,
    CMD_LIST = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_OP,
    S_LIST
  } state_t;

  typedef enum logic [1:0] {
    CM_HOLD,
    CM_INSERT,
    CM_SHIFT
  } cell_mode_t;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [LVL_W-1:0] lvl;
  } entry_t;

  typedef struct packed {
    cell_mode_t mode;
    entry_t     ins;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== sv/tlpq_cell.sv =====
// One slot of the sorted chain: holds an entry, inserts, or takes its neighbor's.
`default_nettype none

module tlpq_cell (
  input  wire                       clk,
  input  wire tlpq_pkg::cell_ctrl_t ctrl,
  input  wire                       occupied,
  input  wire tlpq_pkg::entry_t     prev_entry,
  input  wire                       prev_after,
  input  wire tlpq_pkg::entry_t     next_entry,
  output tlpq_pkg::entry_t          entry,
  output logic                      after
);
  import tlpq_pkg::*;

  entry_t entry_next;

  // new word goes behind every stored entry of equal or higher level
  assign after = occupied && (entry.lvl >= ctrl.ins.lvl);

  always_comb begin
    entry_next = entry;
    case (ctrl.mode)
      CM_HOLD:   entry_next = entry;
      CM_INSERT: begin
        if (after) begin
          entry_next = entry;
        end else if (prev_after) begin
          entry_next = ctrl.ins;
        end else begin
          entry_next = prev_entry;
        end
      end
      CM_SHIFT:  entry_next = next_entry;
      default:   entry_next = entry;
    endcase
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

`default_nettype wire

// ===== sv/three_level_priority_queue_top.sv =====
// Top level of the three-level priority queue: control, count and chain of cells.
//
// Usage:
//   Command channel: drive command, item_id and priority_req with start high;
//   the word is taken at a clock edge where start is high and busy is low.
//   Commands: enqueue (0), dequeue head (1), list all (2); code 3 is dropped
//   and gives no result. Priority 3 is treated as 2.
//   Result channel: done is high for exactly one cycle per result word, with
//   status, out_id, out_priority and last valid in that cycle. The receiver
//   cannot stall; every word must be taken when shown.
// Command flow:
//   Enqueue, dequeue and an empty list: the result word is registered as the
//   op state ends, busy being high only in that state; a dropped code gives none.
//   List: entries rotate once around the whole chain of CAPACITY cells, one
//   shift a cycle, which brings them back into place; busy for the whole walk
//   and a result word per stored entry at its start, last marking the final
//   one. The rotation length, not the entry count, sets how long busy lasts.
// Reset: rst (synchronous, active high) empties the queue and clears done;
//   cell contents are not cleared, slots past the count are never shown.
`default_nettype none

`include "assert_macros.svh"

module three_level_priority_queue_top (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            start,
  output logic                           busy,
  input  wire  [1:0]                     command,
  input  wire  [tlpq_pkg::ID_W-1:0]      item_id,
  input  wire  [tlpq_pkg::LVL_W-1:0]     priority_req,
  output logic                           done,
  output logic [1:0]                     status,
  output logic [tlpq_pkg::ID_W-1:0]      out_id,
  output logic [tlpq_pkg::LVL_W-1:0]     out_priority,
  output logic                           last
);
  import tlpq_pkg::*;

  state_t            state, state_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [IDX_W-1:0]  step, step_next;
  logic [1:0]        cmd;
  logic [ID_W-1:0]   id_r;
  logic [LVL_W-1:0]  lvl_r;

  logic              done_next;
  logic [1:0]        status_next;
  logic [ID_W-1:0]   out_id_next;
  logic [LVL_W-1:0]  out_priority_next;
  logic              last_next;

  cell_ctrl_t        ctrl;
  entry_t            cells [CAPACITY];
  logic              after_v [CAPACITY];
  logic              occ [CAPACITY];

  logic              accept;
  logic              full;
  logic              empty;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign full   = (count == CNT_W'(CAPACITY));
  assign empty  = (count == '0);

  // ---------------------------------------------------------------- cells
  // Slot 0 is the head. Insert shifts the tail one slot away from the head;
  // shift moves every slot toward the head, the head wrapping to the tail.
  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      assign occ[gi] = (CNT_W'(gi) < count);
      if (gi == 0) begin : g_head
        tlpq_cell u_cell (
          .clk        (clk),
          .ctrl       (ctrl),
          .occupied   (occ[gi]),
          .prev_entry (ctrl.ins),
          .prev_after (1'b1),
          .next_entry (cells[(gi + 1) % CAPACITY]),
          .entry      (cells[gi]),
          .after      (after_v[gi])
        );
      end else begin : g_body
        tlpq_cell u_cell (
          .clk        (clk),
          .ctrl       (ctrl),
          .occupied   (occ[gi]),
          .prev_entry (cells[gi - 1]),
          .prev_after (after_v[gi - 1]),
          .next_entry (cells[(gi + 1) % CAPACITY]),
          .entry      (cells[gi]),
          .after      (after_v[gi])
        );
      end
    end
  endgenerate

  always_comb begin
    ctrl.ins.id  = id_r;
    ctrl.ins.lvl = lvl_r;
    ctrl.mode    = CM_HOLD;
    case (state)
      S_OP: begin
        if (cmd == CMD_ENQ && !full) begin
          ctrl.mode = CM_INSERT;
        end else if (cmd == CMD_DEQ && !empty) begin
          ctrl.mode = CM_SHIFT;
        end
      end
      S_LIST:  ctrl.mode = CM_SHIFT;
      default: ctrl.mode = CM_HOLD;
    endcase
  end

  // ---------------------------------------------------------------- control
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (command == CMD_LIST && !empty) begin
            state_next = S_LIST;
          end else begin
            state_next = S_OP;
          end
        end
      end
      S_OP:    state_next = S_IDLE;
      S_LIST: begin
        if (step == IDX_W'(CAPACITY - 1)) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    count_next = count;
    step_next  = '0;
    case (state)
      S_OP: begin
        if (cmd == CMD_ENQ && !full) begin
          count_next = count + CNT_W'(1);
        end else if (cmd == CMD_DEQ && !empty) begin
          count_next = count - CNT_W'(1);
        end
      end
      S_LIST:  step_next = step + IDX_W'(1);
      default: step_next = '0;
    endcase
  end

  // result word, registered below
  always_comb begin
    done_next         = 1'b0;
    status_next       = ST_OK;
    out_id_next       = '0;
    out_priority_next = '0;
    last_next         = 1'b1;
    case (state)
      S_OP: begin
        if (cmd == CMD_ENQ) begin
          done_next   = 1'b1;
          status_next = full ? ST_FULL : ST_OK;
        end else if (cmd == CMD_DEQ || cmd == CMD_LIST) begin
          done_next = 1'b1;
          if (empty) begin
            status_next = ST_EMPTY;
          end else begin
            out_id_next       = cells[0].id;
            out_priority_next = cells[0].lvl;
          end
        end
      end
      S_LIST: begin
        done_next         = (CNT_W'(step) < count);
        out_id_next       = cells[0].id;
        out_priority_next = cells[0].lvl;
        last_next         = ((CNT_W'(step) + CNT_W'(1)) == count);
      end
      default: done_next = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      step  <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      step  <= step_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd   <= command;
      id_r  <= item_id;
      lvl_r <= (priority_req > LVL_TOP) ? LVL_TOP : priority_req;
    end
    status       <= status_next;
    out_id       <= out_id_next;
    out_priority <= out_priority_next;
    last         <= last_next;
  end

  // ---------------------------------------------------------------- checks
  `CHK(a_count_cap, count <= CNT_W'(CAPACITY), "entry count beyond capacity")
  `CHK(a_full_word, (done && status == ST_FULL) |-> (full && last), "full reported while not full")
  `CHK(a_enq_grow, (state == S_OP && cmd == CMD_ENQ && !full) |=> (count == $past(count) + CNT_W'(1)), "enqueue did not add an entry")
  `CHK_ALWAYS(a_idle_reset, $past(rst) |-> (!busy && !done), "block not idle after reset")

endmodule

`default_nettype wire
